FILE: rtl/core/lus_pkg.sv
// Shared types, constants and the micro-op table of the 3x3 LU solver.
// Used by lus_front, lus_engine and lu_solve_3x3_top; depends on nothing.
package lus_pkg;

    localparam int DW              = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int NFIELD          = 12;
    localparam int NSLOT           = 25;
    localparam int SLOT_W          = 5;
    localparam int PC_W            = 5;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_PIV = 2'd1;
    localparam logic [1:0] ST_SAT = 2'd2;

    localparam logic [1:0] OP_MUL = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_DIV = 2'd2;
    localparam logic [1:0] OP_OUT = 2'd3;

    localparam logic [SLOT_W-1:0] R_U11 = 5'd0;
    localparam logic [SLOT_W-1:0] R_U12 = 5'd1;
    localparam logic [SLOT_W-1:0] R_U13 = 5'd2;
    localparam logic [SLOT_W-1:0] R_A21 = 5'd3;
    localparam logic [SLOT_W-1:0] R_A22 = 5'd4;
    localparam logic [SLOT_W-1:0] R_A23 = 5'd5;
    localparam logic [SLOT_W-1:0] R_A31 = 5'd6;
    localparam logic [SLOT_W-1:0] R_A32 = 5'd7;
    localparam logic [SLOT_W-1:0] R_A33 = 5'd8;
    localparam logic [SLOT_W-1:0] R_R1  = 5'd9;
    localparam logic [SLOT_W-1:0] R_R2  = 5'd10;
    localparam logic [SLOT_W-1:0] R_R3  = 5'd11;
    localparam logic [SLOT_W-1:0] R_L21 = 5'd12;
    localparam logic [SLOT_W-1:0] R_L31 = 5'd13;
    localparam logic [SLOT_W-1:0] R_U22 = 5'd14;
    localparam logic [SLOT_W-1:0] R_U23 = 5'd15;
    localparam logic [SLOT_W-1:0] R_L32 = 5'd16;
    localparam logic [SLOT_W-1:0] R_U33 = 5'd17;
    localparam logic [SLOT_W-1:0] R_Y2  = 5'd18;
    localparam logic [SLOT_W-1:0] R_Y3  = 5'd19;
    localparam logic [SLOT_W-1:0] R_X3  = 5'd20;
    localparam logic [SLOT_W-1:0] R_X2  = 5'd21;
    localparam logic [SLOT_W-1:0] R_X1  = 5'd22;
    localparam logic [SLOT_W-1:0] R_T1  = 5'd23;
    localparam logic [SLOT_W-1:0] R_T2  = 5'd24;

    typedef struct packed {
        logic signed [DW-1:0] a11;
        logic signed [DW-1:0] a12;
        logic signed [DW-1:0] a13;
        logic signed [DW-1:0] a21;
        logic signed [DW-1:0] a22;
        logic signed [DW-1:0] a23;
        logic signed [DW-1:0] a31;
        logic signed [DW-1:0] a32;
        logic signed [DW-1:0] a33;
        logic signed [DW-1:0] rhs1;
        logic signed [DW-1:0] rhs2;
        logic signed [DW-1:0] rhs3;
    } t_in_item;

    typedef struct packed {
        logic signed [DW-1:0] sol1;
        logic signed [DW-1:0] sol2;
        logic signed [DW-1:0] sol3;
        logic [1:0]           status;
    } t_out_item;

    typedef struct packed {
        t_in_item item;
        logic     piv0;
    } t_job;

    typedef struct packed {
        logic [1:0]        kind;
        logic [SLOT_W-1:0] a;
        logic [SLOT_W-1:0] b;
        logic [SLOT_W-1:0] d;
        logic              zchk;
    } t_uop;

    typedef struct packed {
        logic                 sat;
        logic signed [DW-1:0] val;
    } t_clamp;

    function automatic t_clamp clamp64(input logic signed [63:0] v);
        t_clamp c;
        if (v > 64'sd2147483647) begin
            c.sat = 1'b1;
            c.val = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            c.sat = 1'b1;
            c.val = 32'sh80000000;
        end else begin
            c.sat = 1'b0;
            c.val = v[DW-1:0];
        end
        return c;
    endfunction

    function automatic logic signed [DW-1:0] get_field(input t_in_item it,
                                                       input logic [3:0] idx);
        logic signed [DW-1:0] v;
        case (idx)
            4'd0:    v = it.a11;
            4'd1:    v = it.a12;
            4'd2:    v = it.a13;
            4'd3:    v = it.a21;
            4'd4:    v = it.a22;
            4'd5:    v = it.a23;
            4'd6:    v = it.a31;
            4'd7:    v = it.a32;
            4'd8:    v = it.a33;
            4'd9:    v = it.rhs1;
            4'd10:   v = it.rhs2;
            4'd11:   v = it.rhs3;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic t_uop uop_rom(input logic [PC_W-1:0] pc);
        t_uop u;
        case (pc)
            5'd0:    u = '{OP_DIV, R_A21, R_U11, R_L21, 1'b0};
            5'd1:    u = '{OP_DIV, R_A31, R_U11, R_L31, 1'b0};
            5'd2:    u = '{OP_MUL, R_L21, R_U12, R_T1,  1'b0};
            5'd3:    u = '{OP_SUB, R_A22, R_T1,  R_U22, 1'b1};
            5'd4:    u = '{OP_MUL, R_L21, R_U13, R_T1,  1'b0};
            5'd5:    u = '{OP_SUB, R_A23, R_T1,  R_U23, 1'b0};
            5'd6:    u = '{OP_MUL, R_L31, R_U12, R_T1,  1'b0};
            5'd7:    u = '{OP_SUB, R_A32, R_T1,  R_T1,  1'b0};
            5'd8:    u = '{OP_DIV, R_T1,  R_U22, R_L32, 1'b0};
            5'd9:    u = '{OP_MUL, R_L31, R_U13, R_T1,  1'b0};
            5'd10:   u = '{OP_SUB, R_A33, R_T1,  R_T2,  1'b0};
            5'd11:   u = '{OP_MUL, R_L32, R_U23, R_T1,  1'b0};
            5'd12:   u = '{OP_SUB, R_T2,  R_T1,  R_U33, 1'b1};
            5'd13:   u = '{OP_MUL, R_L21, R_R1,  R_T1,  1'b0};
            5'd14:   u = '{OP_SUB, R_R2,  R_T1,  R_Y2,  1'b0};
            5'd15:   u = '{OP_MUL, R_L31, R_R1,  R_T1,  1'b0};
            5'd16:   u = '{OP_SUB, R_R3,  R_T1,  R_T2,  1'b0};
            5'd17:   u = '{OP_MUL, R_L32, R_Y2,  R_T1,  1'b0};
            5'd18:   u = '{OP_SUB, R_T2,  R_T1,  R_Y3,  1'b0};
            5'd19:   u = '{OP_DIV, R_Y3,  R_U33, R_X3,  1'b0};
            5'd20:   u = '{OP_MUL, R_U23, R_X3,  R_T1,  1'b0};
            5'd21:   u = '{OP_SUB, R_Y2,  R_T1,  R_T1,  1'b0};
            5'd22:   u = '{OP_DIV, R_T1,  R_U22, R_X2,  1'b0};
            5'd23:   u = '{OP_MUL, R_U12, R_X2,  R_T1,  1'b0};
            5'd24:   u = '{OP_SUB, R_R1,  R_T1,  R_T1,  1'b0};
            5'd25:   u = '{OP_MUL, R_U13, R_X3,  R_T2,  1'b0};
            5'd26:   u = '{OP_SUB, R_T1,  R_T2,  R_T1,  1'b0};
            5'd27:   u = '{OP_DIV, R_T1,  R_U11, R_X1,  1'b0};
            default: u = '{OP_OUT, R_X2,  R_X3,  R_X1,  1'b0};
        endcase
        return u;
    endfunction

endpackage

FILE: rtl/core/lus_fifo.sv
// Small register queue with show-ahead output, used between the solver stages.
// Depends on nothing but its parameters.
module lus_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_empty,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + AW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + (AW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - (AW+1)'(1);
            end
        end
    end

    a_cnt_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_cnt == $past(r_cnt) + (AW+1)'(1)))
        else $error("queue count did not rise on a lone push");
    a_cnt_dn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_pop && !do_push) |=> (r_cnt == $past(r_cnt) - (AW+1)'(1)))
        else $error("queue count did not fall on a lone pop");
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt <= (AW+1)'(DEPTH)))
        else $error("queue count exceeds its depth");

endmodule

FILE: rtl/core/lus_front.sv
// Input stage of the solver: registers each system and flags a zero leading pivot.
// Depends on lus_pkg.
module lus_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  lus_pkg::t_in_item i_item,
    output logic              o_push,
    input  logic              i_full,
    output lus_pkg::t_job     o_job
);
    import lus_pkg::*;

    logic r_vld;
    t_job r_job;
    logic acc;

    assign full   = r_vld && i_full;
    assign acc    = push && !full;
    assign o_push = r_vld;
    assign o_job  = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (acc) begin
            r_vld <= 1'b1;
        end else if (!i_full) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_job.item <= i_item;
            r_job.piv0 <= (i_item.a11 == '0);
        end
    end

endmodule

FILE: rtl/core/lus_engine.sv
// Back end of the solver: runs the elimination micro-program with one multiplier,
// one subtractor and a one-bit-per-cycle divider over a small value memory. Uses lus_pkg.
module lus_engine #(
    parameter int FRAC_BITS = lus_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    input  lus_pkg::t_job      i_job,
    output logic               o_job_pop,
    output logic               o_res_push,
    input  logic               i_res_full,
    output lus_pkg::t_out_item o_res
);
    import lus_pkg::*;

    localparam int NW  = DW + FRAC_BITS + 2;
    localparam int CNW = $clog2(NW);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_EX   = 3'd3;
    localparam logic [2:0] S_MULP = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_DIVF = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic signed [DW-1:0] r_mem [NSLOT];
    logic [2:0]           r_state;
    logic [PC_W-1:0]      r_pc;
    logic [3:0]           r_ld;
    t_job                 r_job;
    logic signed [DW-1:0] r_ra, r_rb, r_last;
    logic signed [63:0]   r_prod;
    logic [DW:0]          r_rem;
    logic [DW+1:0]        r_den;
    logic [NW-1:0]        r_num, r_quo;
    logic [CNW-1:0]       r_cnt;
    logic                 r_neg, r_sat;
    t_out_item            r_res;

    t_uop                 uop;
    t_clamp               wb;
    logic                 wb_en;
    logic [SLOT_W-1:0]    wb_addr;
    logic signed [63:0]   mrnd, mshf, sdif, dq;
    logic [DW:0]          ua, ud;
    logic [NW-1:0]        dnum;
    logic [DW+1:0]        trial;
    logic                 qbit;
    logic                 piv;

    assign uop = uop_rom(r_pc);

    always_comb begin
        mrnd  = r_prod + (64'sd1 <<< (FRAC_BITS - 1));
        mshf  = mrnd >>> FRAC_BITS;
        sdif  = 64'(r_ra) - 64'(r_rb);
        dq    = r_neg ? -$signed(64'(r_quo)) : $signed(64'(r_quo));
        ua    = r_ra[DW-1] ? (DW+1)'(-$signed({r_ra[DW-1], r_ra})) : {1'b0, r_ra};
        ud    = r_rb[DW-1] ? (DW+1)'(-$signed({r_rb[DW-1], r_rb})) : {1'b0, r_rb};
        dnum  = {ua, {FRAC_BITS{1'b0}}, 1'b0} + {{(NW-DW-1){1'b0}}, ud};
        trial = {r_rem, r_num[NW-1]};
        qbit  = (trial >= r_den);
    end

    always_comb begin
        wb_en   = 1'b0;
        wb_addr = uop.d;
        wb      = '0;
        case (r_state)
            S_LOAD: begin
                wb_en   = 1'b1;
                wb_addr = SLOT_W'(r_ld);
                wb.val  = get_field(r_job.item, r_ld);
            end
            S_EX: begin
                if (uop.kind == OP_SUB) begin
                    wb_en = 1'b1;
                    wb    = clamp64(sdif);
                end
            end
            S_MULP: begin
                wb_en = 1'b1;
                wb    = clamp64(mshf);
            end
            S_DIVF: begin
                wb_en = 1'b1;
                wb    = clamp64(dq);
            end
            default: begin
                wb_en = 1'b0;
            end
        endcase
    end

    assign piv        = (r_state == S_EX) && (uop.kind == OP_SUB) && uop.zchk
                        && (wb.val == '0);
    assign o_job_pop  = (r_state == S_IDLE) && i_job_valid;
    assign o_res_push = (r_state == S_DONE) && !i_res_full;
    assign o_res      = r_res;

    always_ff @(posedge i_clk) begin
        if (wb_en) begin
            r_mem[wb_addr] <= wb.val;
        end
        if (r_state == S_RD) begin
            r_ra <= r_mem[uop.a];
            r_rb <= r_mem[uop.b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job <= i_job;
        end
        if (wb_en && (r_state != S_LOAD)) begin
            r_last <= wb.val;
        end
        if ((r_state == S_EX) && (uop.kind == OP_MUL)) begin
            r_prod <= r_ra * r_rb;
        end
        if ((r_state == S_EX) && (uop.kind == OP_DIV)) begin
            r_neg <= r_ra[DW-1] ^ r_rb[DW-1];
            r_num <= dnum;
            r_den <= {ud, 1'b0};
            r_rem <= '0;
            r_quo <= '0;
        end
        if (r_state == S_DIV) begin
            r_num <= {r_num[NW-2:0], 1'b0};
            r_quo <= {r_quo[NW-2:0], qbit};
            r_rem <= qbit ? (DW+1)'(trial - r_den) : trial[DW:0];
        end
        if (o_job_pop && i_job.piv0) begin
            r_res <= '{sol1: '0, sol2: '0, sol3: '0, status: ST_PIV};
        end else if (piv) begin
            r_res <= '{sol1: '0, sol2: '0, sol3: '0, status: ST_PIV};
        end else if ((r_state == S_EX) && (uop.kind == OP_OUT)) begin
            r_res <= '{sol1: r_last, sol2: r_ra, sol3: r_rb,
                       status: r_sat ? ST_SAT : ST_OK};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= '0;
            r_ld    <= '0;
            r_cnt   <= '0;
            r_sat   <= 1'b0;
        end else begin
            if (wb_en && (r_state != S_LOAD)) begin
                r_sat <= r_sat | wb.sat;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_ld    <= '0;
                        r_pc    <= '0;
                        r_sat   <= 1'b0;
                        r_state <= i_job.piv0 ? S_DONE : S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_ld <= r_ld + 4'd1;
                    if (r_ld == 4'(NFIELD - 1)) begin
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_EX;
                end
                S_EX: begin
                    case (uop.kind)
                        OP_MUL: r_state <= S_MULP;
                        OP_SUB: begin
                            r_pc    <= r_pc + PC_W'(1);
                            r_state <= piv ? S_DONE : S_RD;
                        end
                        OP_DIV: begin
                            r_cnt   <= CNW'(NW - 1);
                            r_state <= S_DIV;
                        end
                        default: r_state <= S_DONE;
                    endcase
                end
                S_MULP: begin
                    r_pc    <= r_pc + PC_W'(1);
                    r_state <= S_RD;
                end
                S_DIV: begin
                    r_cnt <= r_cnt - CNW'(1);
                    if (r_cnt == '0) begin
                        r_state <= S_DIVF;
                    end
                end
                S_DIVF: begin
                    r_pc    <= r_pc + PC_W'(1);
                    r_state <= S_RD;
                end
                S_DONE: begin
                    if (!i_res_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_pop_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |=> ((r_state == S_LOAD) || (r_state == S_DONE)))
        else $error("job taken but engine did not start");
    a_div_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DIV) && (r_cnt == '0)) |=> (r_state == S_DIVF))
        else $error("divider did not finish after its last step");
    a_piv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_push && (o_res.status == ST_PIV)) |->
        ((o_res.sol1 == '0) && (o_res.sol2 == '0) && (o_res.sol3 == '0)))
        else $error("zero-pivot result carries a nonzero solution");

endmodule

FILE: rtl/core/lu_solve_3x3_top.sv
// Top level of the 3x3 LU linear solver: front stage, job queue, engine and result queue.
// Depends on lus_pkg, lus_front, lus_fifo and lus_engine.
//
//   channel  | handshake         | payload
//   input    | push / full       | i_item (t_in_item: a11..a33, rhs1..rhs3)
//   result   | pop / empty       | o_item (t_out_item: sol1..sol3, status)
//
// The shared divider retires one quotient bit per cycle for each of the six divisions
// of a system. A system with a zero leading pivot skips the load and the micro-program
// and goes straight to its result.
// Reset is synchronous and active low and empties both queues.
// Input beats are taken while the engine works until the job queue fills; a stalled
// result beat waits in the two-entry result queue, and once that is full the engine
// holds its finished result and takes no new job.
module lu_solve_3x3_top #(
    parameter int FRAC_BITS   = lus_pkg::FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH = lus_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  lus_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output lus_pkg::t_out_item o_item
);
    import lus_pkg::*;

    localparam int JW = $bits(t_job);
    localparam int RW = $bits(t_out_item);

    logic      f_push, q_full, q_empty, e_pop, r_push, r_full;
    t_job      f_job, q_job;
    t_out_item e_res;
    logic [JW-1:0] q_data;
    logic [RW-1:0] o_data;

    assign q_job  = t_job'(q_data);
    assign o_item = t_out_item'(o_data);

    lus_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .o_push  (f_push),
        .i_full  (q_full),
        .o_job   (f_job)
    );

    lus_fifo #(.WIDTH(JW), .DEPTH(QUEUE_DEPTH)) u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .o_full  (q_full),
        .i_data  (f_job),
        .o_empty (q_empty),
        .i_pop   (e_pop),
        .o_data  (q_data)
    );

    lus_engine #(.FRAC_BITS(FRAC_BITS)) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!q_empty),
        .i_job       (q_job),
        .o_job_pop   (e_pop),
        .o_res_push  (r_push),
        .i_res_full  (r_full),
        .o_res       (e_res)
    );

    lus_fifo #(.WIDTH(RW), .DEPTH(2)) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_push),
        .o_full  (r_full),
        .i_data  (e_res),
        .o_empty (empty),
        .i_pop   (pop),
        .o_data  (o_data)
    );

endmodule
